FILE: rtl/core/ssit_pkg.sv
// Shared types, widths and tables for the strict segment intersection core.
// No dependencies; every core file refers to it by scoped names.
package ssit_pkg;

    // Coordinate width and the widths that follow from it
    localparam int CW = 32;          // coordinate
    localparam int DW = CW + 1;      // coordinate difference
    localparam int PW = 2 * DW;      // difference product
    localparam int XW = PW + 1;      // cross product

    // Point order: 0 A start, 1 A end, 2 B start, 3 B end.
    // Orientation k tests point ORI_B[k] against the line ORI_O[k] to ORI_A[k].
    localparam logic [3:0][1:0] ORI_O = {2'd2, 2'd2, 2'd0, 2'd0};
    localparam logic [3:0][1:0] ORI_A = {2'd3, 2'd3, 2'd1, 2'd1};
    localparam logic [3:0][1:0] ORI_B = {2'd1, 2'd0, 2'd3, 2'd2};

    // Request payload
    typedef struct packed {
        logic signed [CW-1:0] seg_a_start_x;
        logic signed [CW-1:0] seg_a_start_y;
        logic signed [CW-1:0] seg_a_end_x;
        logic signed [CW-1:0] seg_a_end_y;
        logic signed [CW-1:0] seg_b_start_x;
        logic signed [CW-1:0] seg_b_start_y;
        logic signed [CW-1:0] seg_b_end_x;
        logic signed [CW-1:0] seg_b_end_y;
    } t_seg_in;

    // Result payload
    typedef struct packed {
        logic intersects;
        logic collinear;
    } t_seg_out;

    // After the difference stage: four differences per orientation,
    // plus the extent of each segment, indexed [segment][axis], axis 0 is x
    typedef struct packed {
        logic [3:0][DW-1:0]      dax;
        logic [3:0][DW-1:0]      dby;
        logic [3:0][DW-1:0]      day;
        logic [3:0][DW-1:0]      dbx;
        logic [1:0][1:0][CW-1:0] lo;
        logic [1:0][1:0][CW-1:0] hi;
    } t_diff;

    // After the product stage
    typedef struct packed {
        logic [3:0][PW-1:0] pp;
        logic [3:0][PW-1:0] pq;
        logic               overlap;
    } t_prod;

    // After the sign stage
    typedef struct packed {
        logic [3:0] zero;
        logic [3:0] neg;
        logic       overlap;
    } t_sign;

    // Exact two's complement difference, one bit wider than the inputs
    function automatic logic [DW-1:0] dsub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

endpackage

FILE: rtl/core/strict_segment_intersection_test_core.sv
// Top level of the strict segment intersection core: four-stage pipeline.
// Depends on ssit_pkg, ssit_diff, ssit_mult, ssit_sign and ssit_decide.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_req (t_seg_in)
//   result    out        o_valid / i_stall    o_rsp (t_seg_out)
//
// One request per cycle is taken while o_stall is low; each result passes through
// the registered stages difference, multiply, cross sign and decide in turn.
// Reset clears only the stage valid bits.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up; o_stall rises only when every stage is full and i_stall is high.
module strict_segment_intersection_test_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ssit_pkg::t_seg_in  i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output ssit_pkg::t_seg_out o_rsp
);

    logic            v1;
    logic            v2;
    logic            v3;
    logic            adv1;
    logic            adv2;
    logic            adv3;
    logic            adv4;
    ssit_pkg::t_diff d1;
    ssit_pkg::t_prod d2;
    ssit_pkg::t_sign d3;

    // Advance a stage when it is empty or the stage after it advances
    assign adv4    = !o_valid || !i_stall;
    assign adv3    = !v3 || adv4;
    assign adv2    = !v2 || adv3;
    assign adv1    = !v1 || adv2;
    assign o_stall = !adv1;

    ssit_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_adv   (adv1),
        .i_req   (i_req),
        .o_valid (v1),
        .o_data  (d1)
    );

    ssit_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_adv   (adv2),
        .i_data  (d1),
        .o_valid (v2),
        .o_data  (d2)
    );

    ssit_sign u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .i_adv   (adv3),
        .i_data  (d2),
        .o_valid (v3),
        .o_data  (d3)
    );

    ssit_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .i_adv   (adv4),
        .i_data  (d3),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // Upstream is held back only when the whole pipeline is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (v1 && v2 && v3 && o_valid && i_stall))
        else $error("request held back with room in the pipeline");

    // A request leaving the first stage lands in the second
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v1 && adv2) |=> v2)
        else $error("request lost between difference and product stages");

    // The collinear flag follows the four zero signs of the sign stage
    a_collinear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v3 && adv4) |=> (o_valid && (o_rsp.collinear == $past(&d3.zero))))
        else $error("collinear flag disagrees with cross product signs");

endmodule

FILE: rtl/core/ssit_diff.sv
// First pipeline stage: coordinate differences and segment extents.
// Depends on ssit_pkg.
module ssit_diff (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_adv,
    input  ssit_pkg::t_seg_in i_req,
    output logic             o_valid,
    output ssit_pkg::t_diff  o_data
);

    logic [3:0][ssit_pkg::CW-1:0] px;
    logic [3:0][ssit_pkg::CW-1:0] py;
    ssit_pkg::t_diff              n_data;
    ssit_pkg::t_diff              r_data;
    logic                         r_valid;

    assign px = {i_req.seg_b_end_x, i_req.seg_b_start_x, i_req.seg_a_end_x, i_req.seg_a_start_x};
    assign py = {i_req.seg_b_end_y, i_req.seg_b_start_y, i_req.seg_a_end_y, i_req.seg_a_start_y};

    // Form the differences for each orientation and the per-axis extents
    always_comb begin
        n_data = r_data;
        for (int k = 0; k < 4; k++) begin
            n_data.dax[k] = ssit_pkg::dsub(px[ssit_pkg::ORI_A[k]], px[ssit_pkg::ORI_O[k]]);
            n_data.dby[k] = ssit_pkg::dsub(py[ssit_pkg::ORI_B[k]], py[ssit_pkg::ORI_O[k]]);
            n_data.day[k] = ssit_pkg::dsub(py[ssit_pkg::ORI_A[k]], py[ssit_pkg::ORI_O[k]]);
            n_data.dbx[k] = ssit_pkg::dsub(px[ssit_pkg::ORI_B[k]], px[ssit_pkg::ORI_O[k]]);
        end
        for (int s = 0; s < 2; s++) begin
            if ($signed(px[2*s]) < $signed(px[2*s+1])) begin
                n_data.lo[s][0] = px[2*s];
                n_data.hi[s][0] = px[2*s+1];
            end else begin
                n_data.lo[s][0] = px[2*s+1];
                n_data.hi[s][0] = px[2*s];
            end
            if ($signed(py[2*s]) < $signed(py[2*s+1])) begin
                n_data.lo[s][1] = py[2*s];
                n_data.hi[s][1] = py[2*s+1];
            end else begin
                n_data.lo[s][1] = py[2*s+1];
                n_data.hi[s][1] = py[2*s];
            end
        end
    end

    // Advance the stage; hold while the next stage is full and stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/ssit_mult.sv
// Second pipeline stage: the eight difference products and the strict overlap test.
// Depends on ssit_pkg.
module ssit_mult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_adv,
    input  ssit_pkg::t_diff i_data,
    output logic            o_valid,
    output ssit_pkg::t_prod o_data
);

    ssit_pkg::t_prod n_data;
    ssit_pkg::t_prod r_data;
    logic            r_valid;

    // Sign-extend to the product width; the low bits of the product are exact
    function automatic logic [ssit_pkg::PW-1:0] smul(input logic [ssit_pkg::DW-1:0] a,
                                                     input logic [ssit_pkg::DW-1:0] b);
        logic [ssit_pkg::PW-1:0] ae;
        logic [ssit_pkg::PW-1:0] be;
        ae = {{ssit_pkg::DW{a[ssit_pkg::DW-1]}}, a};
        be = {{ssit_pkg::DW{b[ssit_pkg::DW-1]}}, b};
        return ae * be;
    endfunction

    always_comb begin
        n_data = r_data;
        for (int k = 0; k < 4; k++) begin
            n_data.pp[k] = smul(i_data.dax[k], i_data.dby[k]);
            n_data.pq[k] = smul(i_data.day[k], i_data.dbx[k]);
        end
        // Projections must overlap strictly on both axes
        n_data.overlap = ($signed(i_data.hi[0][0]) > $signed(i_data.lo[1][0])) &&
                         ($signed(i_data.hi[0][1]) > $signed(i_data.lo[1][1])) &&
                         ($signed(i_data.hi[1][0]) > $signed(i_data.lo[0][0])) &&
                         ($signed(i_data.hi[1][1]) > $signed(i_data.lo[0][1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/ssit_sign.sv
// Third pipeline stage: subtract product pairs and keep the sign of each cross product.
// Depends on ssit_pkg.
module ssit_sign (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_adv,
    input  ssit_pkg::t_prod i_data,
    output logic            o_valid,
    output ssit_pkg::t_sign o_data
);

    logic [3:0][ssit_pkg::XW-1:0] xprod;
    ssit_pkg::t_sign              n_data;
    ssit_pkg::t_sign              r_data;
    logic                         r_valid;

    always_comb begin
        n_data = r_data;
        for (int k = 0; k < 4; k++) begin
            xprod[k] = {i_data.pp[k][ssit_pkg::PW-1], i_data.pp[k]}
                     - {i_data.pq[k][ssit_pkg::PW-1], i_data.pq[k]};
            n_data.zero[k] = (xprod[k] == '0);
            n_data.neg[k]  = xprod[k][ssit_pkg::XW-1];
        end
        n_data.overlap = i_data.overlap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/ssit_decide.sv
// Final stage and output register: collinear and strict-crossing decision.
// Depends on ssit_pkg.
module ssit_decide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_adv,
    input  ssit_pkg::t_sign    i_data,
    output logic               o_valid,
    output ssit_pkg::t_seg_out o_rsp
);

    logic               ab;
    logic               ba;
    ssit_pkg::t_seg_out n_rsp;
    ssit_pkg::t_seg_out r_rsp;
    logic               r_valid;

    // B's endpoints on strictly opposite sides of A, and A's of B
    always_comb begin
        ab = !i_data.zero[0] && !i_data.zero[1] && (i_data.neg[0] != i_data.neg[1]);
        ba = !i_data.zero[2] && !i_data.zero[3] && (i_data.neg[2] != i_data.neg[3]);
        n_rsp.collinear  = &i_data.zero;
        n_rsp.intersects = n_rsp.collinear ? i_data.overlap : (ab && ba);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv && i_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

FILE: tb/strict_segment_intersection_test_core_tb.sv
// Testbench for the strict segment intersection core: drives segment-pair requests,
// predicts each crossing verdict exactly and checks every result in order.
// Depends on ssit_pkg and strict_segment_intersection_test_core.
`timescale 1ns / 1ps

module strict_segment_intersection_test_core_tb;

    typedef logic signed [ssit_pkg::CW-1:0] t_coord;
    typedef logic signed [ssit_pkg::DW-1:0] t_delta;
    typedef logic signed [ssit_pkg::PW-1:0] t_prod_s;
    typedef logic signed [ssit_pkg::XW-1:0] t_cross;

    localparam t_coord CMIN = {1'b1, {(ssit_pkg::CW-1){1'b0}}};
    localparam t_coord CMAX = {1'b0, {(ssit_pkg::CW-1){1'b1}}};

    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 383;
    localparam int PRINT_CAP    = 50;

    // Scoreboard: predicts each verdict when its request is taken, checks results in order
    class crossing_scoreboard;
        ssit_pkg::t_seg_out verdicts_due[$];
        int                 mismatches;
        int                 requests_seen;
        int                 results_seen;
        int                 crossings_seen;
        int                 collinear_seen;

        task report_mismatch(input string what);
            if (mismatches < PRINT_CAP)
                $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Sign of (a - o) x (b - o), worked out at full width
        function int orient_sign(input t_coord ox, input t_coord oy, input t_coord ax,
                                 input t_coord ay, input t_coord bx, input t_coord by);
            t_delta  dax, day, dbx, dby;
            t_prod_s pp, pq;
            t_cross  cr;
            dax = ax - ox;
            day = ay - oy;
            dbx = bx - ox;
            dby = by - oy;
            pp  = dax * dby;
            pq  = day * dbx;
            cr  = t_cross'(pp) - t_cross'(pq);
            if (cr == 0)
                return 0;
            return cr < 0 ? -1 : 1;
        endfunction

        function ssit_pkg::t_seg_out crossing_verdict(input ssit_pkg::t_seg_in r);
            ssit_pkg::t_seg_out v;
            int     s1, s2, s3, s4;
            t_coord ax_hi, ax_lo, ay_hi, ay_lo, bx_hi, bx_lo, by_hi, by_lo;
            s1 = orient_sign(r.seg_a_start_x, r.seg_a_start_y, r.seg_a_end_x, r.seg_a_end_y,
                             r.seg_b_start_x, r.seg_b_start_y);
            s2 = orient_sign(r.seg_a_start_x, r.seg_a_start_y, r.seg_a_end_x, r.seg_a_end_y,
                             r.seg_b_end_x, r.seg_b_end_y);
            s3 = orient_sign(r.seg_b_start_x, r.seg_b_start_y, r.seg_b_end_x, r.seg_b_end_y,
                             r.seg_a_start_x, r.seg_a_start_y);
            s4 = orient_sign(r.seg_b_start_x, r.seg_b_start_y, r.seg_b_end_x, r.seg_b_end_y,
                             r.seg_a_end_x, r.seg_a_end_y);
            ax_hi = r.seg_a_start_x > r.seg_a_end_x ? r.seg_a_start_x : r.seg_a_end_x;
            ax_lo = r.seg_a_start_x > r.seg_a_end_x ? r.seg_a_end_x : r.seg_a_start_x;
            ay_hi = r.seg_a_start_y > r.seg_a_end_y ? r.seg_a_start_y : r.seg_a_end_y;
            ay_lo = r.seg_a_start_y > r.seg_a_end_y ? r.seg_a_end_y : r.seg_a_start_y;
            bx_hi = r.seg_b_start_x > r.seg_b_end_x ? r.seg_b_start_x : r.seg_b_end_x;
            bx_lo = r.seg_b_start_x > r.seg_b_end_x ? r.seg_b_end_x : r.seg_b_start_x;
            by_hi = r.seg_b_start_y > r.seg_b_end_y ? r.seg_b_start_y : r.seg_b_end_y;
            by_lo = r.seg_b_start_y > r.seg_b_end_y ? r.seg_b_end_y : r.seg_b_start_y;
            if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0) begin
                // Collinear: strict overlap on both axes, so shared endpoints fail
                v.collinear  = 1'b1;
                v.intersects = (ax_hi > bx_lo) && (ay_hi > by_lo) &&
                               (bx_hi > ax_lo) && (by_hi > ay_lo);
            end else begin
                v.collinear  = 1'b0;
                v.intersects = (s1 != 0) && (s2 != 0) && (s1 != s2) &&
                               (s3 != 0) && (s4 != 0) && (s3 != s4);
            end
            return v;
        endfunction

        function void note_request(input ssit_pkg::t_seg_in r);
            verdicts_due.push_back(crossing_verdict(r));
            requests_seen++;
        endfunction

        task check_result(input ssit_pkg::t_seg_out got);
            ssit_pkg::t_seg_out want;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request waiting",
                                          results_seen));
                results_seen++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.intersects !== want.intersects)
                report_mismatch($sformatf("result %0d intersects %b, expected %b",
                                          results_seen, got.intersects, want.intersects));
            if (got.collinear !== want.collinear)
                report_mismatch($sformatf("result %0d collinear %b, expected %b",
                                          results_seen, got.collinear, want.collinear));
            if (want.intersects)
                crossings_seen++;
            if (want.collinear)
                collinear_seen++;
            results_seen++;
        endtask
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    ssit_pkg::t_seg_in  i_req   = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    ssit_pkg::t_seg_out o_rsp;

    crossing_scoreboard sb;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit hold_off_req  = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int input_stalls  = 0;

    strict_segment_intersection_test_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: random stalls, or one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Check each result taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_rsp);
        if (i_rst_n && i_valid && o_stall)
            input_stalls++;
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no traffic for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one request, with random idle cycles first, and hold it until taken
    task send_request(input ssit_pkg::t_seg_in req);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_request(req);
    endtask

    task offer_pair(input t_coord ax, input t_coord ay, input t_coord bx, input t_coord by,
                    input t_coord cx, input t_coord cy, input t_coord dx, input t_coord dy);
        ssit_pkg::t_seg_in r;
        r.seg_a_start_x = ax;
        r.seg_a_start_y = ay;
        r.seg_a_end_x   = bx;
        r.seg_a_end_y   = by;
        r.seg_b_start_x = cx;
        r.seg_b_start_y = cy;
        r.seg_b_end_x   = dx;
        r.seg_b_end_y   = dy;
        send_request(r);
    endtask

    function automatic t_coord full_coord();
        return t_coord'({$urandom, $urandom});
    endfunction

    function automatic t_coord small_coord(input int span);
        return t_coord'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Bias towards the corners of the coordinate range
    function automatic t_coord corner_coord();
        case ($urandom_range(0, 5))
            0: return CMIN;
            1: return CMAX;
            2: return '0;
            3: return '1;
            4: return t_coord'(1);
            default: return full_coord();
        endcase
    endfunction

    // One random pair, mixing generic shapes with the degenerate ones
    function automatic ssit_pkg::t_seg_in random_pair();
        ssit_pkg::t_seg_in r;
        t_coord px, py, ddx, ddy, yl;
        int     t0, t1, t2, t3;
        px  = ($urandom_range(0, 1)) ? full_coord() : small_coord(1000);
        py  = ($urandom_range(0, 1)) ? full_coord() : small_coord(1000);
        ddx = small_coord(4);
        ddy = small_coord(4);
        t0  = int'($urandom_range(0, 6)) - 3;
        t1  = int'($urandom_range(0, 6)) - 3;
        t2  = int'($urandom_range(0, 6)) - 3;
        t3  = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                r = {full_coord(), full_coord(), full_coord(), full_coord(),
                     full_coord(), full_coord(), full_coord(), full_coord()};
            end
            3, 4: begin
                r = {small_coord(8), small_coord(8), small_coord(8), small_coord(8),
                     small_coord(8), small_coord(8), small_coord(8), small_coord(8)};
            end
            5, 6: begin
                // Four points on one line through a base point
                r.seg_a_start_x = px + t_coord'(t0) * ddx;
                r.seg_a_start_y = py + t_coord'(t0) * ddy;
                r.seg_a_end_x   = px + t_coord'(t1) * ddx;
                r.seg_a_end_y   = py + t_coord'(t1) * ddy;
                r.seg_b_start_x = px + t_coord'(t2) * ddx;
                r.seg_b_start_y = py + t_coord'(t2) * ddy;
                r.seg_b_end_x   = px + t_coord'(t3) * ddx;
                r.seg_b_end_y   = py + t_coord'(t3) * ddy;
            end
            7: begin
                r = {corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                     corner_coord(), corner_coord(), corner_coord(), corner_coord()};
            end
            8: begin
                // Shared endpoint between the segments
                r = {px, py, px + small_coord(6), py + small_coord(6),
                     px + small_coord(6), py + small_coord(6), px + small_coord(6),
                     py + small_coord(6)};
                if ($urandom_range(0, 1)) begin
                    r.seg_b_start_x = r.seg_a_end_x;
                    r.seg_b_start_y = r.seg_a_end_y;
                end else begin
                    r.seg_b_end_x = r.seg_a_start_x;
                    r.seg_b_end_y = r.seg_a_start_y;
                end
            end
            default: begin
                // Axis-parallel collinear pair, horizontal or vertical
                yl = ($urandom_range(0, 1)) ? full_coord() : small_coord(4);
                r = {px + small_coord(4), yl, px + small_coord(4), yl,
                     px + small_coord(4), yl, px + small_coord(4), yl};
                if ($urandom_range(0, 1))
                    r = {r.seg_a_start_y, r.seg_a_start_x, r.seg_a_end_y, r.seg_a_end_x,
                         r.seg_b_start_y, r.seg_b_start_x, r.seg_b_end_y, r.seg_b_end_x};
            end
        endcase
        return r;
    endfunction

    initial begin
        sb = new();
        tx_idle_pct = 34;
        rx_idle_pct = 51;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs: corners, crossings and every degenerate shape
        offer_pair('0, '0, '0, '0, '0, '0, '0, '0);
        offer_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        offer_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        offer_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        offer_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
        offer_pair(CMIN, '0, CMAX, '0, '0, CMIN, '0, CMAX);
        offer_pair(CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX);
        offer_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX - 1, CMAX);
        offer_pair(0, 0, 4, 4, 0, 4, 4, 0);
        offer_pair(-1, -1, 1, 1, -1, 1, 1, -1);
        offer_pair(0, 0, 4, 4, 4, 4, 8, 0);
        offer_pair(0, 0, 4, 0, 2, 0, 2, 4);
        offer_pair(0, 0, 4, 4, 2, 2, 6, 6);
        offer_pair(0, 0, 2, 2, 2, 2, 4, 4);
        offer_pair(0, 0, 1, 1, 3, 3, 5, 5);
        offer_pair(0, 0, 4, 0, 2, 0, 6, 0);
        offer_pair(3, -5, 3, 5, 3, 0, 3, 9);
        offer_pair(2, 2, 2, 2, 0, 0, 4, 4);
        offer_pair(0, 0, 4, 4, 0, 1, 4, 5);
        offer_pair(0, 0, 1, 1, 0, 4, 4, 2);
        offer_pair(5, 5, 5, 5, 5, 5, 5, 5);

        // Random pairs, sender idling less than receiver
        repeat (PHASE_ITEMS)
            send_request(random_pair());

        // Swap the idling
        tx_idle_pct = 51;
        rx_idle_pct = 34;
        repeat (PHASE_ITEMS)
            send_request(random_pair());

        // Back-to-back traffic with one long hold-off on the result side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off_req = 1'b1;
        repeat (PHASE_ITEMS)
            send_request(random_pair());
        i_valid <= 1'b0;

        // Drain, then allow the pipeline latency to pass
        while (sb.verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d segment pairs and %0d results: %0d crossing, %0d collinear.",
                 sb.requests_seen, sb.results_seen, sb.crossings_seen, sb.collinear_seen);
        $display("Request side stalled for %0d cycles; %0d mismatches found.",
                 input_stalls, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ssit_pkg.sv
rtl/core/ssit_diff.sv
rtl/core/ssit_mult.sv
rtl/core/ssit_sign.sv
rtl/core/ssit_decide.sv
rtl/core/strict_segment_intersection_test_core.sv
tb/strict_segment_intersection_test_core_tb.sv
